// File: rtl/dmx_pkg.sv
// ----------------------------------------------------------------------------
// dmx_pkg
// Shared types and constants of the distributed mutex node.
// ----------------------------------------------------------------------------
package dmx_pkg;

	localparam int unsigned MAX_NODES_DEF = 15;
	localparam int unsigned SEQ_BITS_DEF  = 16;

	localparam int unsigned OP_W    = 2;
	localparam int unsigned ID_W    = 4;
	localparam int unsigned SEQ_W   = 16;
	localparam int unsigned KIND_W  = 2;
	localparam int unsigned REG_W   = 4;
	localparam int unsigned RIDX_W  = 1;
	localparam int unsigned ID_MAX  = (1 << ID_W) - 1;

	localparam logic [RIDX_W-1:0] REG_MY_ID      = 1'b0;
	localparam logic [RIDX_W-1:0] REG_NODE_COUNT = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_LOCAL_REQ = 2'd0,
		OP_PEER_REQ  = 2'd1,
		OP_PEER_REP  = 2'd2,
		OP_RELEASE   = 2'd3
	} op_t;

	typedef enum logic [KIND_W-1:0] {
		KIND_REQ   = 2'd0,
		KIND_REPLY = 2'd1,
		KIND_ENTER = 2'd2
	} kind_t;

	typedef struct packed {
		logic              valid;
		kind_t             kind;
		logic [ID_W-1:0]   dest;
		logic [SEQ_W-1:0]  seq;
	} res_t;

endpackage

// File: rtl/dmx_emit.sv
// ----------------------------------------------------------------------------
// dmx_emit
// Result stage: holds back one result so the final one of a request can be
// marked last, and drives the registered result ports.
// ----------------------------------------------------------------------------
module dmx_emit (
	input  logic                       clk,
	input  logic                       arst_n,
	input  dmx_pkg::res_t              cand,
	input  logic                       flush,
	output logic                       valid,
	output logic [dmx_pkg::KIND_W-1:0] kind,
	output logic [dmx_pkg::ID_W-1:0]   dest,
	output logic [dmx_pkg::SEQ_W-1:0]  seq_out,
	output logic                       last
);
	import dmx_pkg::*;

	logic pend_valid_q;
	res_t pend_q;
	logic valid_q;
	res_t out_q;
	logic last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_valid_q <= 1'b0;
			valid_q      <= 1'b0;
		end else if (cand.valid) begin
			pend_valid_q <= 1'b1;
			valid_q      <= pend_valid_q;
		end else if (flush) begin
			pend_valid_q <= 1'b0;
			valid_q      <= pend_valid_q;
		end else begin
			valid_q      <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cand.valid) begin
			pend_q <= cand;
			out_q  <= pend_q;
			last_q <= 1'b0;
		end else if (flush) begin
			out_q  <= pend_q;
			last_q <= 1'b1;
		end
	end

	assign valid   = valid_q;
	assign kind    = out_q.kind;
	assign dest    = out_q.dest;
	assign seq_out = out_q.seq;
	assign last    = last_q;

endmodule

// File: rtl/distributed_mutex_node.sv
// ----------------------------------------------------------------------------
// distributed_mutex_node
// One node of Ricart-Agrawala mutual exclusion.
//
// Command channel: op, peer and seq_in are taken at a clock edge with start
// high and busy low; busy then stays high until the node is done.
// Results leave on kind, dest, seq_out and last, one per cycle while valid
// is high; last marks the final result of a command. The receiver cannot
// stall; results are held back only so that the last one can be marked.
// Configuration: wr_en, wr_idx, wr_data write my_node_id (index 0) or
// node_count (index 1) at once; write only while busy is low.
// Sequence: a request or release walks node ids 1..n through one id counter
// and compare, one id per cycle; an incoming request or reply is decided in
// the decide state. A result leaves once the next one is found or the
// command ends; the final result shows in the first cycle with busy low, at
// whose end the next command can be taken.
// Reset clears the node to not requesting, all numbers zero and nothing
// deferred; my_node_id resets to 1 and node_count to 2.
// ----------------------------------------------------------------------------
module distributed_mutex_node #(
	parameter int unsigned MAX_NODES = dmx_pkg::MAX_NODES_DEF,
	parameter int unsigned SEQ_BITS  = dmx_pkg::SEQ_BITS_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [dmx_pkg::OP_W-1:0]    op,
	input  logic [dmx_pkg::ID_W-1:0]    peer,
	input  logic [dmx_pkg::SEQ_W-1:0]   seq_in,
	input  logic                        wr_en,
	input  logic [dmx_pkg::RIDX_W-1:0]  wr_idx,
	input  logic [dmx_pkg::REG_W-1:0]   wr_data,
	output logic                        valid,
	output logic [dmx_pkg::KIND_W-1:0]  kind,
	output logic [dmx_pkg::ID_W-1:0]    dest,
	output logic [dmx_pkg::SEQ_W-1:0]   seq_out,
	output logic                        last
);
	import dmx_pkg::*;

	localparam int unsigned NODE_CAP = (MAX_NODES > ID_MAX) ? ID_MAX : MAX_NODES;

	typedef enum logic [4:0] {
		ST_IDLE   = 5'b00001,
		ST_DECIDE = 5'b00010,
		ST_WALK   = 5'b00100,
		ST_TAIL   = 5'b01000,
		ST_FLUSH  = 5'b10000
	} state_t;

	state_t               state_q;
	logic [ID_W-1:0]      my_id_q;
	logic [ID_W-1:0]      node_cnt_q;
	op_t                  op_q;
	logic [ID_W-1:0]      peer_q;
	logic [SEQ_BITS-1:0]  seq_q;
	logic                 requesting_q;
	logic [SEQ_BITS-1:0]  own_q;
	logic [SEQ_BITS-1:0]  hs_q;
	logic [ID_W-1:0]      pend_cnt_q;
	logic [ID_MAX:0]      dmap_q;
	logic                 bcast_q;
	logic                 enter_q;
	logic [ID_W-1:0]      idx_q;

	logic [ID_W-1:0]      n_eff;
	logic [SEQ_BITS-1:0]  seq_w;
	logic [SEQ_BITS-1:0]  hs_inc;
	logic [SEQ_W-1:0]     own_out;
	logic                 peer_ok;
	logic                 defer;
	logic                 walk_hit;
	res_t                 cand;
	logic                 flush;

	assign n_eff   = (node_cnt_q > ID_W'(NODE_CAP)) ? ID_W'(NODE_CAP) : node_cnt_q;
	assign seq_w   = SEQ_BITS'({{SEQ_BITS{1'b0}}, seq_in});
	assign hs_inc  = (&hs_q) ? hs_q : hs_q + SEQ_BITS'(1);
	assign own_out = SEQ_W'({{SEQ_W{1'b0}}, own_q});
	assign peer_ok = (peer_q != '0) && (peer_q <= n_eff) && (peer_q != my_id_q);
	assign defer   = requesting_q &&
	                 ((seq_q > own_q) || ((seq_q == own_q) && (peer_q > my_id_q)));
	assign walk_hit = (idx_q != my_id_q) && (bcast_q || dmap_q[idx_q]);
	assign busy    = (state_q != ST_IDLE);

	always_comb begin
		cand  = '0;
		flush = 1'b0;
		case (state_q)
			ST_DECIDE: begin
				if (op_q == OP_PEER_REQ && peer_ok && !defer) begin
					cand.valid = 1'b1;
					cand.kind  = KIND_REPLY;
					cand.dest  = peer_q;
				end else if (op_q == OP_PEER_REP && peer_ok && requesting_q &&
				             pend_cnt_q == ID_W'(1)) begin
					cand.valid = 1'b1;
					cand.kind  = KIND_ENTER;
				end
			end
			ST_WALK: begin
				if (walk_hit) begin
					cand.valid = 1'b1;
					cand.kind  = bcast_q ? KIND_REQ : KIND_REPLY;
					cand.dest  = idx_q;
					cand.seq   = own_out;
				end
			end
			ST_TAIL: begin
				if (enter_q) begin
					cand.valid = 1'b1;
					cand.kind  = KIND_ENTER;
				end
			end
			ST_FLUSH: flush = 1'b1;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			my_id_q    <= ID_W'(1);
			node_cnt_q <= ID_W'(2);
		end else if (wr_en) begin
			case (wr_idx)
				REG_MY_ID:      my_id_q    <= wr_data;
				REG_NODE_COUNT: node_cnt_q <= wr_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q   <= op_t'(op);
			peer_q <= peer;
			seq_q  <= seq_w;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			requesting_q <= 1'b0;
			own_q        <= '0;
			hs_q         <= '0;
			pend_cnt_q   <= '0;
			dmap_q       <= '0;
			bcast_q      <= 1'b0;
			enter_q      <= 1'b0;
			idx_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					state_q <= ST_IDLE;
					case (op_q)
						OP_LOCAL_REQ: begin
							if (!requesting_q && my_id_q != '0 && my_id_q <= n_eff) begin
								requesting_q <= 1'b1;
								hs_q         <= hs_inc;
								own_q        <= hs_inc;
								pend_cnt_q   <= n_eff - ID_W'(1);
								enter_q      <= (n_eff == ID_W'(1));
								bcast_q      <= 1'b1;
								idx_q        <= ID_W'(1);
								state_q      <= ST_WALK;
							end
						end
						OP_PEER_REQ: begin
							if (peer_ok) begin
								if (seq_q > hs_q) begin
									hs_q <= seq_q;
								end
								if (defer) begin
									dmap_q[peer_q] <= 1'b1;
								end else begin
									state_q <= ST_FLUSH;
								end
							end
						end
						OP_PEER_REP: begin
							if (peer_ok && requesting_q && pend_cnt_q != '0) begin
								pend_cnt_q <= pend_cnt_q - ID_W'(1);
								if (pend_cnt_q == ID_W'(1)) begin
									state_q <= ST_FLUSH;
								end
							end
						end
						OP_RELEASE: begin
							requesting_q <= 1'b0;
							pend_cnt_q   <= '0;
							enter_q      <= 1'b0;
							bcast_q      <= 1'b0;
							idx_q        <= ID_W'(1);
							if (n_eff == '0) begin
								dmap_q <= '0;
							end else begin
								state_q <= ST_WALK;
							end
						end
						default: ;
					endcase
				end
				ST_WALK: begin
					if (idx_q == n_eff) begin
						state_q <= ST_TAIL;
					end else begin
						idx_q <= idx_q + ID_W'(1);
					end
				end
				ST_TAIL: begin
					if (!bcast_q) begin
						dmap_q <= '0;
					end
					state_q <= ST_FLUSH;
				end
				ST_FLUSH: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	dmx_emit u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.cand    (cand),
		.flush   (flush),
		.valid   (valid),
		.kind    (kind),
		.dest    (dest),
		.seq_out (seq_out),
		.last    (last)
	);

endmodule
